/* rtl/core/mlfq_process_scheduler_unit_assert.svh */
// Assertion macros used by the scheduler checker
`ifndef MLFQ_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
`define MLFQ_PROCESS_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MLFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mlfq_pkg.sv */
// Constants, widths and helpers of the multilevel feedback queue scheduler
package mlfq_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int LEVELS    = 16;

    localparam int PID_W   = 16;
    localparam int LVL_W   = 4;
    localparam int QNT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int RS_DEPTH  = LEVELS * MAX_SLOTS;
    localparam int RS_AW     = $clog2(RS_DEPTH);
    localparam int SM_W      = PID_W + LVL_W;

    localparam logic [QNT_W-1:0] QUANTUM_RESET = QNT_W'(100);
    localparam logic             ACT_ADD       = 1'b0;
    localparam logic             ACT_TICK      = 1'b1;

    // Saturate a level to the last queue
    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lv);
        logic [LVL_W-1:0] res;
        res = lv;
        if (32'(lv) >= LEVELS)
        begin
            res = LVL_W'(LEVELS - 1);
        end
        return res;
    endfunction

endpackage

/* rtl/core/mlfq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/mlfq_process_scheduler_unit.sv */
// Flow: an add beat or a tick that keeps its process running goes EXEC then DONE; a tick
// that searches and finds every queue empty goes EXEC, SEL, DONE; a tick that dispatches
// goes EXEC, SEL, RD1, RD2, DONE (queue search, ready-store read, slot-table read). One beat
// is taken at a time: s_tready is high only in IDLE, as the FSM walks the two RAM read ports
// in turn and DONE waits for the output. Reset clears the FIFO heads and counts, run state
// and time at once; quantum length resets to 100. RAMs are not cleared.
module mlfq_process_scheduler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mlfq_pkg::QNT_W-1:0]    cfg_wr_data,    // quantum_length
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tuser,        // action
    input  logic [mlfq_pkg::S_DATA_W-1:0] s_tdata,        // proc_id, start_priority
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted, running_valid, running_pid, running_level, switched, elapsed_ticks
    output logic [mlfq_pkg::M_DATA_W-1:0] m_tdata
);

    import mlfq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_RD2  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              act_reg;
    logic [PID_W-1:0]  pid_in_reg;
    logic [LVL_W-1:0]  lvl_in_reg;
    logic [QNT_W-1:0]  quantum_len_reg;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]  slots_used_reg, slots_used_next;
    logic              run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic [PID_W-1:0]  run_pid_reg, run_pid_next;
    logic [LVL_W-1:0]  run_level_reg, run_level_next;
    logic [QNT_W-1:0]  quantum_left_reg, quantum_left_next;
    logic [SLOT_W-1:0] head_reg [LEVELS];
    logic [SLOT_W-1:0] head_next [LEVELS];
    logic [CNT_W-1:0]  count_reg [LEVELS];
    logic [CNT_W-1:0]  count_next [LEVELS];
    logic              res_acc_reg, res_acc_next;
    logic              res_sw_reg, res_sw_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              accept;
    logic              sel_found;
    logic [LVL_IDX_W-1:0] sel_idx;

    logic              enq_en;
    logic [LVL_W-1:0]  enq_lvl;
    logic [SLOT_W-1:0] enq_slot;
    logic [LVL_IDX_W-1:0] enq_idx;
    logic [CNT_W:0]    enq_sum;
    logic [SLOT_W-1:0] enq_pos;

    logic [QNT_W-1:0]  q_dec;
    logic [LVL_W-1:0]  demote_lvl;

    logic              sm_we, sm_re;
    logic [SLOT_W-1:0] sm_waddr, sm_raddr;
    logic [SM_W-1:0]   sm_wdata, sm_rdata;
    logic              rs_we, rs_re;
    logic [RS_AW-1:0]  rs_waddr, rs_raddr;
    logic [SLOT_W-1:0] rs_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Lowest-numbered non-empty queue
    always_comb
    begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                sel_found = 1'b1;
                sel_idx   = LVL_IDX_W'(l);
            end
        end
    end

    assign q_dec      = quantum_left_reg - QNT_W'(1);
    assign demote_lvl = (32'(run_level_reg) + 1 < LEVELS) ? run_level_reg + LVL_W'(1)
                                                          : run_level_reg;

    // Tail position of the queue being appended to
    assign enq_idx = enq_lvl[LVL_IDX_W-1:0];
    always_comb
    begin
        enq_sum = (CNT_W + 1)'(head_reg[enq_idx]) + (CNT_W + 1)'(count_reg[enq_idx]);
        if (32'(enq_sum) >= MAX_SLOTS)
        begin
            enq_sum = enq_sum - (CNT_W + 1)'(MAX_SLOTS);
        end
        enq_pos = enq_sum[SLOT_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        tick_next         = tick_reg;
        slots_used_next   = slots_used_reg;
        run_valid_next    = run_valid_reg;
        run_slot_next     = run_slot_reg;
        run_pid_next      = run_pid_reg;
        run_level_next    = run_level_reg;
        quantum_left_next = quantum_left_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        res_acc_next      = res_acc_reg;
        res_sw_next       = res_sw_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;

        enq_en   = 1'b0;
        enq_lvl  = lvl_in_reg;
        enq_slot = slots_used_reg[SLOT_W-1:0];
        sm_we    = 1'b0;
        sm_waddr = slots_used_reg[SLOT_W-1:0];
        sm_wdata = {lvl_in_reg, pid_in_reg};
        sm_re    = 1'b0;
        sm_raddr = rs_rdata;
        rs_re    = 1'b0;
        rs_raddr = RS_AW'(sel_idx) * RS_AW'(MAX_SLOTS) + RS_AW'(head_reg[sel_idx]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_sw_next  = 1'b0;
                res_acc_next = 1'b1;
                state_next   = ST_DONE;
                if (act_reg == ACT_ADD)
                begin
                    if (slots_used_reg == CNT_W'(MAX_SLOTS))
                    begin
                        res_acc_next = 1'b0;
                    end
                    else
                    begin
                        sm_we           = 1'b1;
                        enq_en          = 1'b1;
                        slots_used_next = slots_used_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    tick_next = tick_reg + TIME_W'(1);
                    if (run_valid_reg)
                    begin
                        quantum_left_next = q_dec;
                        if (q_dec == '0)
                        begin
                            // expire: demote and requeue before the search
                            sm_we          = 1'b1;
                            sm_waddr       = run_slot_reg;
                            sm_wdata       = {demote_lvl, run_pid_reg};
                            enq_en         = 1'b1;
                            enq_lvl        = demote_lvl;
                            enq_slot       = run_slot_reg;
                            run_valid_next = 1'b0;
                            state_next     = ST_SEL;
                        end
                    end
                    else
                    begin
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                if (sel_found)
                begin
                    rs_re = 1'b1;
                    head_next[sel_idx] = (head_reg[sel_idx] == SLOT_W'(MAX_SLOTS - 1))
                                         ? '0 : head_reg[sel_idx] + SLOT_W'(1);
                    count_next[sel_idx] = count_reg[sel_idx] - CNT_W'(1);
                    state_next = ST_RD1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD1:
            begin
                sm_re         = 1'b1;
                run_slot_next = rs_rdata;
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                run_pid_next      = sm_rdata[PID_W-1:0];
                run_level_next    = sm_rdata[SM_W-1:PID_W];
                run_valid_next    = 1'b1;
                quantum_left_next = quantum_len_reg;
                res_sw_next       = 1'b1;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, tick_reg, res_sw_reg,
                                     run_valid_reg ? run_level_reg : LVL_W'(0),
                                     run_valid_reg ? run_pid_reg : PID_W'(0),
                                     run_valid_reg, res_acc_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Append, dropped when the queue is full
        rs_we = 1'b0;
        if (enq_en && count_reg[enq_idx] != CNT_W'(MAX_SLOTS))
        begin
            rs_we = 1'b1;
            count_next[enq_idx] = count_reg[enq_idx] + CNT_W'(1);
        end
    end

    assign rs_waddr = RS_AW'(enq_idx) * RS_AW'(MAX_SLOTS) + RS_AW'(enq_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            quantum_len_reg  <= QUANTUM_RESET;
            tick_reg         <= '0;
            slots_used_reg   <= '0;
            run_valid_reg    <= 1'b0;
            run_slot_reg     <= '0;
            run_pid_reg      <= '0;
            run_level_reg    <= '0;
            quantum_left_reg <= '0;
            res_acc_reg      <= 1'b0;
            res_sw_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            tick_reg         <= tick_next;
            slots_used_reg   <= slots_used_next;
            run_valid_reg    <= run_valid_next;
            run_slot_reg     <= run_slot_next;
            run_pid_reg      <= run_pid_next;
            run_level_reg    <= run_level_next;
            quantum_left_reg <= quantum_left_next;
            res_acc_reg      <= res_acc_next;
            res_sw_reg       <= res_sw_next;
            m_tvalid_reg     <= m_tvalid_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            if (cfg_wr_en)
            begin
                quantum_len_reg <= cfg_wr_data;
            end
        end
    end

    // Beat payload and result data
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            act_reg    <= s_tuser;
            pid_in_reg <= s_tdata[PID_W-1:0];
            lvl_in_reg <= clamp_level(s_tdata[PID_W+LVL_W-1:PID_W]);
        end
    end

    mlfq_ram #(
        .WIDTH (SM_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    mlfq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RS_DEPTH)
    ) u_ready_mem (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (enq_slot),
        .re    (rs_re),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

endmodule

/* rtl/core/mlfq_checker.sv */
// Port-level checks of the scheduler, bound to the top level
`include "mlfq_process_scheduler_unit_assert.svh"

module mlfq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mlfq_pkg::M_DATA_W-1:0] m_tdata
);

    import mlfq_pkg::*;

    // m_tdata: accepted[0], running_valid[1], pid[17:2], level[21:18], switched[22]
    `MLFQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
    `MLFQ_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
    `MLFQ_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tdata[1], m_tdata[21:2] == 20'd0, "idle run fields not zero")
    `MLFQ_ASSERT_NOW(a_sw_runs, m_tvalid && m_tdata[22], m_tdata[1], "switch without a running process")
    `MLFQ_ASSERT_NOW(a_rej_nosw, m_tvalid && !m_tdata[0], !m_tdata[22], "rejected add reports a switch")

endmodule

bind mlfq_process_scheduler_unit mlfq_checker u_mlfq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
